[hdl/sbkc_pkg.sv]
// ---------------------------------------------------------------------------
// sbkc_pkg: shared types and constants for the sphere bounds block
// Field widths, transaction structs and register indexes used by the
// pipeline, the square root unit and the divider.
// ---------------------------------------------------------------------------
package sbkc_pkg;

   // fixed datapath widths
   localparam int COORD_W  = 32;   // Q16.16 coordinate
   localparam int RADIUS_W = 31;   // unsigned Q15.16 radius
   localparam int DIFF_W   = 33;   // magnitude of pos - center
   localparam int SQ_W     = 66;   // one squared axis term
   localparam int PROD_W   = 64;   // |diff| * radius
   localparam int RSQ_W    = 62;   // radius squared
   localparam int DIST_W   = 68;   // sum of squares, padded to an even width
   localparam int ROOT_W   = 34;   // floor(sqrt(dist))
   localparam int SREM_W   = 37;   // square root partial remainder
   localparam int QUO_W    = 31;   // surface offset, never above radius
   localparam int SUM_W    = 34;   // center +/- offset before saturation

   // configuration port
   localparam int ADDR_W = 5;
   localparam int DATA_W = 32;

   typedef logic [2:0] reg_index_type;
   localparam reg_index_type REG_CENTER_X    = 3'd0;
   localparam reg_index_type REG_CENTER_Y    = 3'd1;
   localparam reg_index_type REG_CENTER_Z    = 3'd2;
   localparam reg_index_type REG_RADIUS      = 3'd3;
   localparam reg_index_type REG_BOUNDS_MODE = 3'd4;

   localparam logic [RADIUS_W-1:0] RADIUS_RESET = 31'd196608;   // 3.0

   localparam logic            MODE_KILL      = 1'b0;
   localparam logic            MODE_CONSTRAIN = 1'b1;

   // input transaction
   typedef struct packed {
      logic signed [COORD_W-1:0] pos_x;
      logic signed [COORD_W-1:0] pos_y;
      logic signed [COORD_W-1:0] pos_z;
      logic                      last_in;
   } req_type;

   // result transaction
   typedef struct packed {
      logic signed [COORD_W-1:0] out_x;
      logic signed [COORD_W-1:0] out_y;
      logic signed [COORD_W-1:0] out_z;
      logic                      kill_flag;
      logic                      moved_flag;
      logic                      last_out;
   } rsp_type;

   // per-item data carried alongside the square root and divider stages
   typedef struct packed {
      req_type                  req;
      logic [2:0]               neg;
      logic [2:0][PROD_W-1:0]   prod;
      logic                     outside;
   } side_type;

endpackage

[hdl/sbkc_sqrt.sv]
// ---------------------------------------------------------------------------
// sbkc_sqrt: pipelined integer square root
// Digit-by-digit restoring square root, one result bit per register stage.
// ---------------------------------------------------------------------------
module sbkc_sqrt (
   input  logic                         clock,
   input  logic                         enable,
   input  logic [sbkc_pkg::DIST_W-1:0]  sq_dist,
   output logic [sbkc_pkg::ROOT_W-1:0]  root
);
   import sbkc_pkg::*;

   logic [SREM_W-1:0] rem_ff  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];
   logic [DIST_W-1:0] bits_ff [ROOT_W];

   genvar g;
   generate
      for (g = 0; g < ROOT_W; g++) begin : g_stage
         logic [SREM_W-1:0] rem_i, rem2, trial, rem_in;
         logic [ROOT_W-1:0] root_i, root_in;
         logic [DIST_W-1:0] bits_i, bits_in;
         logic              ge;

         if (g == 0) begin : g_first
            assign rem_i  = '0;
            assign root_i = '0;
            assign bits_i = sq_dist;
         end else begin : g_next
            assign rem_i  = rem_ff[g-1];
            assign root_i = root_ff[g-1];
            assign bits_i = bits_ff[g-1];
         end

         // bring down two bits, try root*4+1
         always_comb begin
            rem2    = {rem_i[SREM_W-3:0], bits_i[DIST_W-1 -: 2]};
            trial   = {1'b0, root_i, 2'b01};
            ge      = (rem2 >= trial);
            rem_in  = ge ? (rem2 - trial) : rem2;
            root_in = {root_i[ROOT_W-2:0], ge};
            bits_in = {bits_i[DIST_W-3:0], 2'b00};
         end

         always_ff @(posedge clock) begin
            if (enable) begin
               rem_ff[g]  <= rem_in;
               root_ff[g] <= root_in;
               bits_ff[g] <= bits_in;
            end
         end
      end
   endgenerate

   assign root = root_ff[ROOT_W-1];

endmodule

[hdl/sbkc_div.sv]
// ---------------------------------------------------------------------------
// sbkc_div: pipelined restoring divider
// Produces a QUO_W-bit quotient, one bit per stage; the caller guarantees
// the quotient fits (numerator below divisor << QUO_W).
// ---------------------------------------------------------------------------
module sbkc_div (
   input  logic                         clock,
   input  logic                         enable,
   input  logic [sbkc_pkg::PROD_W-1:0]  num,
   input  logic [sbkc_pkg::ROOT_W-1:0]  den,
   output logic [sbkc_pkg::QUO_W-1:0]   quo
);
   import sbkc_pkg::*;

   logic [ROOT_W-1:0] rem_ff [QUO_W];
   logic [QUO_W-1:0]  low_ff [QUO_W];
   logic [QUO_W-1:0]  quo_ff [QUO_W];
   logic [ROOT_W-1:0] den_ff [QUO_W];

   genvar g;
   generate
      for (g = 0; g < QUO_W; g++) begin : g_stage
         logic [ROOT_W-1:0] rem_i, rem_in, den_i;
         logic [QUO_W-1:0]  low_i, low_in, quo_i, quo_in;
         logic [ROOT_W:0]   r2;
         logic              ge;

         if (g == 0) begin : g_first
            assign rem_i = {{(ROOT_W-(PROD_W-QUO_W)){1'b0}}, num[PROD_W-1:QUO_W]};
            assign low_i = num[QUO_W-1:0];
            assign quo_i = '0;
            assign den_i = den;
         end else begin : g_next
            assign rem_i = rem_ff[g-1];
            assign low_i = low_ff[g-1];
            assign quo_i = quo_ff[g-1];
            assign den_i = den_ff[g-1];
         end

         // shift in one numerator bit, subtract when it fits
         always_comb begin
            r2     = {rem_i, low_i[QUO_W-1]};
            ge     = (r2 >= {1'b0, den_i});
            rem_in = ge ? ROOT_W'(r2 - {1'b0, den_i}) : r2[ROOT_W-1:0];
            low_in = {low_i[QUO_W-2:0], 1'b0};
            quo_in = {quo_i[QUO_W-2:0], ge};
         end

         always_ff @(posedge clock) begin
            if (enable) begin
               rem_ff[g] <= rem_in;
               low_ff[g] <= low_in;
               quo_ff[g] <= quo_in;
               den_ff[g] <= den_i;
            end
         end
      end
   endgenerate

   assign quo = quo_ff[QUO_W-1];

endmodule

[hdl/sphere_bounds_kill_or_constrain.sv]
// ---------------------------------------------------------------------------
// sphere_bounds_kill_or_constrain: particle sphere bounds, kill or constrain
// Squared distance test against a configured sphere; outside particles are
// flagged for removal or pulled onto the surface.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/req_stall | req_data (sbkc_pkg::req_type)
//   rsp     | out       | rsp_valid/rsp_stall | rsp_data (sbkc_pkg::rsp_type)
//   csr     | in/out    | APB psel/penable    | csr_pwdata / csr_prdata
//
// One transaction enters per cycle while no stalled result holds the pipeline;
// the path runs through the 34-stage square root and the 31-stage divider.
// Reset is synchronous and clears all valid bits and the configuration registers.
// A stalled result holds the whole pipeline in place; req_stall follows.
// ---------------------------------------------------------------------------
module sphere_bounds_kill_or_constrain (
   input  logic                         clock,
   input  logic                         reset,
   // input channel
   input  logic                         req_valid,
   output logic                         req_stall,
   input  sbkc_pkg::req_type            req_data,
   // result channel
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output sbkc_pkg::rsp_type            rsp_data,
   // configuration
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [sbkc_pkg::ADDR_W-1:0]  csr_paddr,
   input  logic [sbkc_pkg::DATA_W-1:0]  csr_pwdata,
   output logic [sbkc_pkg::DATA_W-1:0]  csr_prdata,
   output logic                         csr_pready
);
   import sbkc_pkg::*;

   localparam int LINE_LEN = ROOT_W + QUO_W;

   // configuration registers
   logic [COORD_W-1:0]  center_ff [3];
   logic [RADIUS_W-1:0] radius_ff;
   logic                mode_ff;
   reg_index_type       csr_index;
   logic                csr_write;

   assign csr_index  = csr_paddr[4:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_ff[0] <= '0;
         center_ff[1] <= '0;
         center_ff[2] <= '0;
         radius_ff    <= RADIUS_RESET;
         mode_ff      <= MODE_KILL;
      end else if (csr_write) begin
         case (csr_index)
            REG_CENTER_X:    center_ff[0] <= csr_pwdata;
            REG_CENTER_Y:    center_ff[1] <= csr_pwdata;
            REG_CENTER_Z:    center_ff[2] <= csr_pwdata;
            REG_RADIUS:      radius_ff    <= csr_pwdata[RADIUS_W-1:0];
            REG_BOUNDS_MODE: mode_ff      <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   // register read back
   always_comb begin
      case (csr_index)
         REG_CENTER_X:    csr_prdata = center_ff[0];
         REG_CENTER_Y:    csr_prdata = center_ff[1];
         REG_CENTER_Z:    csr_prdata = center_ff[2];
         REG_RADIUS:      csr_prdata = {1'b0, radius_ff};
         REG_BOUNDS_MODE: csr_prdata = {{(DATA_W-1){1'b0}}, mode_ff};
         default:         csr_prdata = '0;
      endcase
   end

   // global pipeline advance
   logic    advance;
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // stage 1: per-axis difference, sign and magnitude
   logic [COORD_W-1:0] pos_a [3];
   logic [DIFF_W-1:0]  diff_a [3];
   logic [DIFF_W-1:0]  abs_in [3];
   logic [2:0]         neg_in;

   logic               v1_ff;
   req_type            req1_ff;
   logic [DIFF_W-1:0]  abs1_ff [3];
   logic [2:0]         neg1_ff;

   assign pos_a[0] = req_data.pos_x;
   assign pos_a[1] = req_data.pos_y;
   assign pos_a[2] = req_data.pos_z;

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         diff_a[a] = {pos_a[a][COORD_W-1], pos_a[a]}
                   - {center_ff[a][COORD_W-1], center_ff[a]};
         neg_in[a] = diff_a[a][DIFF_W-1];
         abs_in[a] = neg_in[a] ? (~diff_a[a] + 1'b1) : diff_a[a];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         req1_ff <= req_data;
         neg1_ff <= neg_in;
         for (int a = 0; a < 3; a++) abs1_ff[a] <= abs_in[a];
      end
   end

   // stage 2: squares, radius products and radius squared
   logic               v2_ff;
   req_type            req2_ff;
   logic [2:0]         neg2_ff;
   logic [SQ_W-1:0]    sq2_ff [3];
   logic [2:0][PROD_W-1:0] prod2_ff;
   logic [RSQ_W-1:0]   rsq2_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         req2_ff <= req1_ff;
         neg2_ff <= neg1_ff;
         rsq2_ff <= {{(RSQ_W-RADIUS_W){1'b0}}, radius_ff}
                  * {{(RSQ_W-RADIUS_W){1'b0}}, radius_ff};
         for (int a = 0; a < 3; a++) begin
            sq2_ff[a]   <= {{(SQ_W-DIFF_W){1'b0}}, abs1_ff[a]}
                         * {{(SQ_W-DIFF_W){1'b0}}, abs1_ff[a]};
            prod2_ff[a] <= {{(PROD_W-DIFF_W){1'b0}}, abs1_ff[a]}
                         * {{(PROD_W-RADIUS_W){1'b0}}, radius_ff};
         end
      end
   end

   // stage 3: squared distance and outside test
   logic              v3_ff;
   side_type          side3_ff;
   side_type          side3_in;
   logic [DIST_W-1:0] dist3_ff;
   logic [DIST_W-1:0] dist_in;

   always_comb begin
      dist_in          = DIST_W'(sq2_ff[0]) + DIST_W'(sq2_ff[1]) + DIST_W'(sq2_ff[2]);
      side3_in.req     = req2_ff;
      side3_in.neg     = neg2_ff;
      side3_in.prod    = prod2_ff;
      side3_in.outside = (dist_in > DIST_W'(rsq2_ff));
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         side3_ff <= side3_in;
         dist3_ff <= dist_in;
      end
   end

   // valid bits for the front stages
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // side line alongside the square root and divider stages
   logic [LINE_LEN-1:0] v_line_ff;
   side_type            side_line_ff [LINE_LEN];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_line_ff <= '0;
      end else if (advance) begin
         v_line_ff <= {v_line_ff[LINE_LEN-2:0], v3_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         side_line_ff[0] <= side3_ff;
         for (int k = 1; k < LINE_LEN; k++) side_line_ff[k] <= side_line_ff[k-1];
      end
   end

   // distance: floor(sqrt(dist))
   logic [ROOT_W-1:0] root;

   sbkc_sqrt u_sqrt (
      .clock   (clock),
      .enable  (advance),
      .sq_dist (dist3_ff),
      .root    (root)
   );

   // offset per axis: |diff| * radius / root
   logic [QUO_W-1:0] quo [3];

   genvar ga;
   generate
      for (ga = 0; ga < 3; ga++) begin : g_axis
         sbkc_div u_div (
            .clock  (clock),
            .enable (advance),
            .num    (side_line_ff[ROOT_W-1].prod[ga]),
            .den    (root),
            .quo    (quo[ga])
         );
      end
   endgenerate

   // output stage: surface point, saturation and flags
   side_type           side_out;
   logic [SUM_W-1:0]   sum_a [3];
   logic [COORD_W-1:0] surf_a [3];
   logic [COORD_W-1:0] orig_a [3];
   logic [COORD_W-1:0] res_a [3];
   logic               move;
   logic               kill;
   rsp_type            rsp_in;

   assign side_out  = side_line_ff[LINE_LEN-1];
   assign orig_a[0] = side_out.req.pos_x;
   assign orig_a[1] = side_out.req.pos_y;
   assign orig_a[2] = side_out.req.pos_z;

   always_comb begin
      kill = side_out.outside && (mode_ff == MODE_KILL);
      move = side_out.outside && (mode_ff == MODE_CONSTRAIN);
      for (int a = 0; a < 3; a++) begin
         sum_a[a] = side_out.neg[a]
                  ? ({{(SUM_W-COORD_W){center_ff[a][COORD_W-1]}}, center_ff[a]}
                     - {{(SUM_W-QUO_W){1'b0}}, quo[a]})
                  : ({{(SUM_W-COORD_W){center_ff[a][COORD_W-1]}}, center_ff[a]}
                     + {{(SUM_W-QUO_W){1'b0}}, quo[a]});
         // saturate when the top bits disagree
         if (sum_a[a][SUM_W-1] && !(&sum_a[a][SUM_W-2:COORD_W-1]))
            surf_a[a] = {1'b1, {(COORD_W-1){1'b0}}};
         else if (!sum_a[a][SUM_W-1] && (|sum_a[a][SUM_W-2:COORD_W-1]))
            surf_a[a] = {1'b0, {(COORD_W-1){1'b1}}};
         else
            surf_a[a] = sum_a[a][COORD_W-1:0];
         res_a[a] = move ? surf_a[a] : orig_a[a];
      end
      rsp_in.out_x      = res_a[0];
      rsp_in.out_y      = res_a[1];
      rsp_in.out_z      = res_a[2];
      rsp_in.kill_flag  = kill;
      rsp_in.moved_flag = move;
      rsp_in.last_out   = side_out.req.last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= v_line_ff[LINE_LEN-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) rsp_data_ff <= rsp_in;
   end

   // checks
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.kill_flag && rsp_data_ff.moved_flag))
      else $error("kill and moved flags both set");

   a_line_holds: assert property (@(posedge clock) disable iff (reset)
      (!advance && !reset) |=> $stable(v_line_ff))
      else $error("pipeline valid bits moved during a stall");

   a_outside_nonzero: assert property (@(posedge clock) disable iff (reset)
      (v3_ff && side3_ff.outside) |-> (dist3_ff != '0))
      else $error("outside item with zero distance");

endmodule
